[hdl/stmm_pkg.sv]
// ----------------------------------------------------------------------------
// stmm_pkg
// shared constants, codes and control structs for the sparse table min/max
// engine
// ----------------------------------------------------------------------------
package stmm_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int LEVEL_COUNT  = 11;
   localparam int VALUE_W      = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int LEN_W        = IDX_W + 1;
   localparam int LVL_W        = $clog2(LEVEL_COUNT);
   localparam int ADDR_W       = LVL_W + IDX_W;
   localparam int RAM_DEPTH    = LEVEL_COUNT * MAX_ELEMENTS;

   localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(LEVEL_COUNT - 1);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_ELEMENTS);
   localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(1);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_RANGE = 2'd1,
      STATUS_NOT_BUILT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY_READ,
      ST_QUERY_DONE,
      ST_BUILD_READ,
      ST_BUILD_DRAIN
   } state_type;

   // memory port control shared by both level memories
   typedef struct packed {
      logic              we;
      logic              wr_combine;   // write data from the merge, not the request
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } ram_ctl_type;

   typedef struct packed {
      logic       load;
      status_type status;
   } rsp_ctl_type;

   // floor of log2, capped at the top level
   function automatic logic [LVL_W-1:0] floor_log2(input logic [LEN_W-1:0] value);
      logic [LVL_W-1:0] result;
      result = '0;
      for (int b = 0; b < LEN_W; b++) begin
         if (value[b]) begin
            result = LVL_W'(b);
         end
      end
      if (result > LVL_MAX) begin
         result = LVL_MAX;
      end
      return result;
   endfunction

endpackage

[hdl/sparse_table_range_min_max.sv]
// ----------------------------------------------------------------------------
// sparse_table_range_min_max
// sparse table engine answering range minimum and maximum queries
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A write request
// stores one value at level 0. A build request walks levels 1 and up, one
// entry per cycle with a drain state after each level; the pace is set by
// the single write port of each level memory. A query request passes
// through address and memory read, then merge, and its response shows on
// the rsp_ ports for exactly one cycle, the first cycle with busy low,
// marked by rsp_valid. The receiver cannot stall: a response not taken in
// that cycle is gone. Writes and builds give no response.
// array_length may only be changed while busy is low; a change, like an
// element write, marks the tables as not built.
// ----------------------------------------------------------------------------
module sparse_table_range_min_max (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [stmm_pkg::IDX_W-1:0]   req_element_index,
   input  logic signed [stmm_pkg::VALUE_W-1:0] req_element_value,
   input  logic [stmm_pkg::IDX_W-1:0]   req_left_index,
   input  logic [stmm_pkg::IDX_W-1:0]   req_right_index,
   // response channel
   output logic                         rsp_valid,
   output logic signed [stmm_pkg::VALUE_W-1:0] rsp_range_minimum,
   output logic signed [stmm_pkg::VALUE_W-1:0] rsp_range_maximum,
   output logic [1:0]                   rsp_query_status,
   // length register
   input  logic                         csr_write_enable,
   input  logic [stmm_pkg::LEN_W-1:0]   csr_write_data
);
   import stmm_pkg::*;

   // covered length, kept clamped to 1 .. MAX_ELEMENTS
   logic [LEN_W-1:0]           length_ff, length_in;

   // response register
   logic                       rsp_valid_ff;
   logic signed [VALUE_W-1:0]  rsp_min_ff, rsp_min_in;
   logic signed [VALUE_W-1:0]  rsp_max_ff, rsp_max_in;
   status_type                 rsp_status_ff;

   ram_ctl_type                ram_ctl;
   rsp_ctl_type                rsp_ctl;

   // read data of both level memories
   logic signed [VALUE_W-1:0]  min_a, min_b;
   logic signed [VALUE_W-1:0]  max_a, max_b;
   logic signed [VALUE_W-1:0]  min_merge, max_merge;
   logic [VALUE_W-1:0]         min_wdata, max_wdata;

   // length register write with clamp
   always_comb begin
      length_in = length_ff;
      if (csr_write_enable) begin
         if (csr_write_data < LEN_MIN) begin
            length_in = LEN_MIN;
         end else if (csr_write_data > LEN_MAX) begin
            length_in = LEN_MAX;
         end else begin
            length_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_MAX;
      end else begin
         length_ff <= length_in;
      end
   end

   // sequencer for writes, build walk and query addressing
   stmm_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_command       (req_command),
      .req_element_index (req_element_index),
      .req_left_index    (req_left_index),
      .req_right_index   (req_right_index),
      .array_length      (length_ff),
      .length_write      (csr_write_enable),
      .busy              (busy),
      .ram_ctl           (ram_ctl),
      .rsp_ctl           (rsp_ctl)
   );

   // merge of the two windows: serves both the build and the query
   assign min_merge = (min_b < min_a) ? min_b : min_a;
   assign max_merge = (max_a < max_b) ? max_b : max_a;

   // build writes the merge, a write request writes the request value
   assign min_wdata = ram_ctl.wr_combine ? min_merge : req_element_value;
   assign max_wdata = ram_ctl.wr_combine ? max_merge : req_element_value;

   stmm_level_ram u_min_ram (
      .clock   (clock),
      .we      (ram_ctl.we),
      .waddr   (ram_ctl.waddr),
      .wdata   (min_wdata),
      .raddr_a (ram_ctl.raddr_a),
      .raddr_b (ram_ctl.raddr_b),
      .rdata_a (min_a),
      .rdata_b (min_b)
   );

   stmm_level_ram u_max_ram (
      .clock   (clock),
      .we      (ram_ctl.we),
      .waddr   (ram_ctl.waddr),
      .wdata   (max_wdata),
      .raddr_a (ram_ctl.raddr_a),
      .raddr_b (ram_ctl.raddr_b),
      .rdata_a (max_a),
      .rdata_b (max_b)
   );

   // error responses carry zero extremes
   always_comb begin
      if (rsp_ctl.status == STATUS_OK) begin
         rsp_min_in = min_merge;
         rsp_max_in = max_merge;
      end else begin
         rsp_min_in = '0;
         rsp_max_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_ctl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_min_ff    <= rsp_min_in;
         rsp_max_ff    <= rsp_max_in;
         rsp_status_ff <= rsp_ctl.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_minimum = rsp_min_ff;
   assign rsp_range_maximum = rsp_max_ff;
   assign rsp_query_status  = rsp_status_ff;

endmodule

[hdl/stmm_level_ram.sv]
// ----------------------------------------------------------------------------
// stmm_level_ram
// one level table memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module stmm_level_ram (
   input  logic                         clock,
   input  logic                         we,
   input  logic [stmm_pkg::ADDR_W-1:0]  waddr,
   input  logic [stmm_pkg::VALUE_W-1:0] wdata,
   input  logic [stmm_pkg::ADDR_W-1:0]  raddr_a,
   input  logic [stmm_pkg::ADDR_W-1:0]  raddr_b,
   output logic [stmm_pkg::VALUE_W-1:0] rdata_a,
   output logic [stmm_pkg::VALUE_W-1:0] rdata_b
);
   import stmm_pkg::*;

   logic [VALUE_W-1:0] mem [RAM_DEPTH];
   logic [VALUE_W-1:0] rdata_a_ff;
   logic [VALUE_W-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[hdl/stmm_ctrl.sv]
// ----------------------------------------------------------------------------
// stmm_ctrl
// request sequencer: element writes, level build walk and query addressing
// ----------------------------------------------------------------------------
module stmm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [1:0]                  req_command,
   input  logic [stmm_pkg::IDX_W-1:0]  req_element_index,
   input  logic [stmm_pkg::IDX_W-1:0]  req_left_index,
   input  logic [stmm_pkg::IDX_W-1:0]  req_right_index,
   input  logic [stmm_pkg::LEN_W-1:0]  array_length,
   input  logic                        length_write,
   output logic                        busy,
   output stmm_pkg::ram_ctl_type       ram_ctl,
   output stmm_pkg::rsp_ctl_type       rsp_ctl
);
   import stmm_pkg::*;

   state_type         state_ff,      state_in;
   logic [LVL_W-1:0]  level_ff,      level_in;
   logic [IDX_W-1:0]  pos_ff,        pos_in;
   logic [IDX_W-1:0]  left_ff,       left_in;
   logic [IDX_W-1:0]  right_ff,      right_in;
   status_type        status_ff,     status_in;
   logic              wr_pending_ff, wr_pending_in;
   logic [ADDR_W-1:0] wr_addr_ff,    wr_addr_in;
   logic              built_ff,      built_in;

   logic              accept;
   logic [LVL_W-1:0]  level_prev;
   logic [LEN_W-1:0]  half;
   logic [LEN_W-1:0]  width;
   logic [LEN_W:0]    width_next;
   logic [LEN_W-1:0]  pos_ext;
   logic [LEN_W-1:0]  span;
   logic [LVL_W-1:0]  k;
   logic [LEN_W-1:0]  hi_ext;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign level_prev = level_ff - LVL_W'(1);
   assign half       = LEN_W'(1) << level_prev;
   assign width      = LEN_W'(1) << level_ff;
   assign width_next = (LEN_W + 1)'(1) << (level_ff + LVL_W'(1));
   assign pos_ext    = {1'b0, pos_ff};
   assign span       = {1'b0, right_ff} - {1'b0, left_ff} + LEN_W'(1);
   assign k          = floor_log2(span);
   assign hi_ext     = {1'b0, right_ff} + LEN_W'(1) - (LEN_W'(1) << k);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_pending_ff <= 1'b0;
         built_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_pending_ff <= wr_pending_in;
         built_ff      <= built_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      pos_ff     <= pos_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      status_ff  <= status_in;
      wr_addr_ff <= wr_addr_in;
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      status_in     = status_ff;
      wr_pending_in = 1'b0;
      wr_addr_in    = wr_addr_ff;
      built_in      = built_ff;

      ram_ctl.we         = wr_pending_ff;
      ram_ctl.wr_combine = wr_pending_ff;
      ram_ctl.waddr      = wr_addr_ff;
      ram_ctl.raddr_a    = '0;
      ram_ctl.raddr_b    = '0;

      rsp_ctl.load   = 1'b0;
      rsp_ctl.status = status_ff;

      if (length_write) begin
         built_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_WRITE: begin
                     ram_ctl.we         = 1'b1;
                     ram_ctl.wr_combine = 1'b0;
                     ram_ctl.waddr      = {LVL_W'(0), req_element_index};
                     built_in           = 1'b0;
                  end
                  CMD_BUILD: begin
                     if (array_length >= LEN_W'(2)) begin
                        level_in = LVL_W'(1);
                        pos_in   = '0;
                        state_in = ST_BUILD_READ;
                     end else begin
                        built_in = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     left_in  = req_left_index;
                     right_in = req_right_index;
                     state_in = ST_QUERY_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QUERY_READ: begin
            ram_ctl.raddr_a = {k, left_ff};
            ram_ctl.raddr_b = {k, hi_ext[IDX_W-1:0]};
            if (!built_ff) begin
               status_in = STATUS_NOT_BUILT;
            end else if (left_ff > right_ff || {1'b0, right_ff} >= array_length) begin
               status_in = STATUS_BAD_RANGE;
            end else begin
               status_in = STATUS_OK;
            end
            state_in = ST_QUERY_DONE;
         end
         ST_QUERY_DONE: begin
            rsp_ctl.load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_BUILD_READ: begin
            // pair of halves from the level below, merged and written next cycle
            ram_ctl.raddr_a = {level_prev, pos_ff};
            ram_ctl.raddr_b = {level_prev, IDX_W'(pos_ext + half)};
            wr_pending_in   = 1'b1;
            wr_addr_in      = {level_ff, pos_ff};
            if (pos_ext + width == array_length) begin
               state_in = ST_BUILD_DRAIN;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         ST_BUILD_DRAIN: begin
            // last write of this level lands before the next level reads it
            if (level_ff != LVL_MAX && width_next <= {1'b0, array_length}) begin
               level_in = level_ff + LVL_W'(1);
               pos_in   = '0;
               state_in = ST_BUILD_READ;
            end else begin
               built_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
